// File: design/sibta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibta_pkg: shared types and constants of the integer-to-ASCII converter
// Word layouts of both ports, the internal command word and the digit table.
// ----------------------------------------------------------------------------
package sibta_pkg;

  localparam int unsigned ValueW       = 32;
  localparam int unsigned RadixW       = 5;
  localparam int unsigned MaxDigits    = 32;
  localparam int unsigned NdW          = $clog2(MaxDigits + 1);
  localparam int unsigned IdxW         = $clog2(MaxDigits);
  localparam int unsigned BitsPerCycle = 8;
  localparam int unsigned DigitCycles  = ValueW / BitsPerCycle;
  localparam int unsigned StepW        = $clog2(DigitCycles);

  localparam logic [RadixW-1:0] RadixMin = 5'd2;
  localparam logic [RadixW-1:0] RadixMax = 5'd16;
  localparam logic [7:0]        CharMinus = 8'h2D;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [RadixW-1:0]        radix;
    logic                     upper_case;
  } in_word_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_word_t;

  // Classified conversion job handed from the front to the back.
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
    logic [RadixW-1:0] base;
    logic              upper;
  } cmd_t;

  // Maps a digit value to its ASCII code in the chosen letter case.
  function automatic logic [7:0] digit_char(logic [3:0] digit, logic upper);
    logic [7:0] code;
    if (digit < 4'd10) begin
      code = 8'h30 + {4'b0000, digit};
    end else begin
      code = (upper ? 8'h41 : 8'h61) + {4'b0000, digit} - 8'd10;
    end
    return code;
  endfunction

endpackage

// File: design/signed_int_to_base_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_base_ascii_top: signed integer to ASCII text in base 2..16
// Converts one signed 32-bit word into a run of character words.
// ----------------------------------------------------------------------------
// Each input word carries a signed value, a base and a letter-case flag; the
// block answers with the text of the value, most significant digit first,
// one character per output word, with a leading '-' for negative values and
// the last flag set on the final character. Bases below 2 are treated as 2
// and bases above 16 as 16. Each item is loaded from the command queue, then
// divided out one digit at a time by the iterative divider in the back end
// (8 quotient bits per cycle), then sent as its characters, the sign first,
// at one per cycle while the receiver keeps popping. The command queue lets
// new words be accepted while a conversion is running.
module signed_int_to_base_ascii_top #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sibta_pkg::in_word_t  in_word_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output sibta_pkg::out_word_t out_word_o,
  output logic                 empty_o
);
  import sibta_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_empty;
  logic queue_pop;

  // The front splits the value into sign and magnitude and clamps the base.
  sibta_front u_front (
    .in_word_i (in_word_i),
    .cmd_o     (front_cmd)
  );

  // The queue holds classified jobs while the back is busy.
  sibta_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (front_cmd),
    .full_o  (full_o),
    .pop_i   (queue_pop),
    .rdata_o (queue_cmd),
    .empty_o (queue_empty)
  );

  // The back divides out the digits and streams the characters.
  sibta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!queue_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: design/sibta_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibta_front: input classification
// Splits the value into sign and magnitude and clamps the base to 2..16.
// ----------------------------------------------------------------------------
module sibta_front (
  input  sibta_pkg::in_word_t in_word_i,
  output sibta_pkg::cmd_t     cmd_o
);
  import sibta_pkg::*;

  logic [ValueW-1:0] raw;

  assign raw = in_word_i.value;

  always_comb begin
    cmd_o.neg   = raw[ValueW-1];
    // The most negative value wraps to 2^31, which is its true magnitude.
    cmd_o.mag   = raw[ValueW-1] ? (~raw + 32'd1) : raw;
    cmd_o.upper = in_word_i.upper_case;
    if (in_word_i.radix < RadixMin) begin
      cmd_o.base = RadixMin;
    end else if (in_word_i.radix > RadixMax) begin
      cmd_o.base = RadixMax;
    end else begin
      cmd_o.base = in_word_i.radix;
    end
  end

endmodule

// File: design/sibta_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibta_fifo: command queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sibta_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sibta_pkg::cmd_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output sibta_pkg::cmd_t rdata_o,
  output logic            empty_o
);
  import sibta_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: design/sibta_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibta_back: digit generation and character output
// Divides the magnitude by the base one digit at a time, then streams text.
// ----------------------------------------------------------------------------
module sibta_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  sibta_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output sibta_pkg::out_word_t out_word_o
);
  import sibta_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StSign = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [ValueW-1:0] dq_q, dq_d;
  logic [3:0]        rem_q, rem_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [NdW-1:0]    nd_q, nd_d;
  logic              neg_q, neg_d, upper_q, upper_d;
  logic [RadixW-1:0] base_q, base_d;
  logic [3:0]        digits_q [MaxDigits];
  logic              dig_we;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q, out_d;
  logic              out_ready;
  logic [ValueW-1:0] div_dq;
  logic [3:0]        div_rem;
  logic [NdW-1:0]    nd_dec;

  assign out_ready  = !out_valid_q || pop_i;
  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;
  assign nd_dec     = nd_q - 1'b1;

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [4:0] r5;
    div_dq  = dq_q;
    div_rem = rem_q;
    for (int i = 0; i < BitsPerCycle; i++) begin
      r5     = {div_rem, div_dq[ValueW-1]};
      div_dq = {div_dq[ValueW-2:0], 1'b0};
      if (r5 >= base_q) begin
        r5        = r5 - base_q;
        div_dq[0] = 1'b1;
      end
      div_rem = r5[3:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    step_d      = step_q;
    nd_d        = nd_q;
    neg_d       = neg_q;
    upper_d     = upper_q;
    base_d      = base_q;
    dig_we      = 1'b0;
    cmd_pop_o   = 1'b0;
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          dq_d      = cmd_i.mag;
          rem_d     = '0;
          step_d    = '0;
          nd_d      = '0;
          neg_d     = cmd_i.neg;
          upper_d   = cmd_i.upper;
          base_d    = cmd_i.base;
          state_d   = StDiv;
        end
      end
      StDiv: begin
        dq_d   = div_dq;
        rem_d  = div_rem;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DigitCycles - 1)) begin
          dig_we = 1'b1;
          rem_d  = '0;
          nd_d   = nd_q + 1'b1;
          if (div_dq == '0 || nd_d == NdW'(MaxDigits)) begin
            state_d = neg_q ? StSign : StEmit;
          end
        end
      end
      StSign: begin
        if (out_ready) begin
          out_valid_d     = 1'b1;
          out_d.character = CharMinus;
          out_d.last      = 1'b0;
          state_d         = StEmit;
        end
      end
      StEmit: begin
        if (out_ready) begin
          out_valid_d     = 1'b1;
          out_d.character = digit_char(digits_q[nd_dec[IdxW-1:0]], upper_q);
          out_d.last      = (nd_q == NdW'(1));
          nd_d            = nd_dec;
          if (nd_q == NdW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      nd_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      nd_q        <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q    <= dq_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    upper_q <= upper_d;
    base_q  <= base_d;
    out_q   <= out_d;
    if (dig_we) begin
      digits_q[nd_q[IdxW-1:0]] <= div_rem;
    end
  end

endmodule

// File: sim/signed_int_to_base_ascii_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_base_ascii_top_test: self-checking bench for the itoa block
// Pushes signed values with a base and a letter-case flag, predicts the text
// of each one character by character, and compares every popped word.
// ----------------------------------------------------------------------------
// A directed burst covers zero, the extremes of the value range, both letter
// cases and the saturated bases. Random words follow in four traffic phases:
// no idling, a slow sender, a slow receiver, and both sides throttled.
module signed_int_to_base_ascii_top_test;
  import sibta_pkg::*;

  // Run shape: number of traffic phases, random words per phase, and the drain wait.
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned WordsPerPhase = 75;
  localparam int unsigned DrainCycles   = 200;

  logic      clk_i;
  logic      rst_ni;
  logic      push_i = 1'b0;
  in_word_t  in_word_i = '0;
  logic      full_o;
  logic      pop_i = 1'b0;
  out_word_t out_word_o;
  logic      empty_o;

  // Words waiting to be pushed, and characters the block still owes us.
  in_word_t  words_to_send[$];
  out_word_t chars_owed[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned num_errors = 0;

  signed_int_to_base_ascii_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_word_i  (in_word_i),
    .full_o     (full_o),
    .pop_i      (pop_i),
    .out_word_o (out_word_o),
    .empty_o    (empty_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Prints one line per mismatch and keeps the count for the final verdict.
  task automatic report_mismatch(input string what);
    num_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Works out the full text of one accepted word and queues it character by
  // character. The magnitude is taken as an unsigned 32-bit number, so the
  // most negative value yields the digits of 2^31 and not a wrapped result.
  task automatic predict_text(input in_word_t w);
    logic [31:0] mag;
    logic [4:0]  base;
    logic [7:0]  digits[$];
    logic [3:0]  d;
    out_word_t   c;
    base = w.radix;
    if (base < RadixMin) begin
      base = RadixMin;
    end else if (base > RadixMax) begin
      base = RadixMax;
    end
    mag = w.value[31] ? (~w.value + 32'd1) : w.value;
    // Digits come out least significant first; push_front keeps them in
    // reading order.
    do begin
      d = 4'(mag % {27'd0, base});
      if (d < 4'd10) begin
        digits.push_front("0" + {4'd0, d});
      end else begin
        digits.push_front((w.upper_case ? "A" : "a") + {4'd0, d} - 8'd10);
      end
      mag = mag / {27'd0, base};
    end while (mag != 32'd0);
    if (w.value[31]) begin
      c.character = "-";
      c.last = 1'b0;
      chars_owed.push_back(c);
    end
    while (digits.size() > 0) begin
      c.character = digits.pop_front();
      c.last = (digits.size() == 0);
      chars_owed.push_back(c);
    end
  endtask

  // Sender side. An accepted word is predicted at the edge that takes it.
  // The next word goes out only once the current one is gone, and with the
  // configured chance the sender idles for a cycle instead.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) begin
        predict_text(in_word_i);
      end
      if (!push_i || !full_o) begin
        if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          push_i <= 1'b1;
          in_word_i <= words_to_send.pop_front();
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // Receiver side. Every word taken is checked against the oldest owed
  // character, field by field; pop is redrawn each cycle to make stalls.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (chars_owed.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%h last=%b",
                                    out_word_o.character, out_word_o.last));
        end else begin
          want = chars_owed.pop_front();
          if (out_word_o.character !== want.character) begin
            report_mismatch($sformatf("character got %h want %h (%c)",
                                      out_word_o.character, want.character,
                                      want.character));
          end
          if (out_word_o.last !== want.last) begin
            report_mismatch($sformatf("last got %b want %b on character %c",
                                      out_word_o.last, want.last, want.character));
          end
        end
      end
      pop_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus and run control. Each phase queues its words and then waits for
  // the sender to drain them before the throttles change.
  initial begin
    in_word_t w;
    int unsigned phase;
    int unsigned n;
    int unsigned mag;

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words: zero, ones, both ends of the range in several bases,
    // both letter cases, and bases that the block must saturate.
    w.upper_case = 1'b0;
    w.value = 32'sd0;           w.radix = 5'd10; words_to_send.push_back(w);
    w.value = 32'sd1;           w.radix = 5'd2;  words_to_send.push_back(w);
    w.value = -32'sd1;          w.radix = 5'd10; words_to_send.push_back(w);
    w.value = 32'sh7FFFFFFF;    w.radix = 5'd2;  words_to_send.push_back(w);
    w.value = 32'sh7FFFFFFF;    w.radix = 5'd16; words_to_send.push_back(w);
    w.value = 32'sh80000000;    w.radix = 5'd2;  words_to_send.push_back(w);
    w.value = 32'sh80000000;    w.radix = 5'd8;  words_to_send.push_back(w);
    w.value = 32'sh80000000;    w.radix = 5'd10; words_to_send.push_back(w);
    w.value = 32'sh80000000;    w.radix = 5'd16; words_to_send.push_back(w);
    w.value = 32'sh80000001;    w.radix = 5'd10; words_to_send.push_back(w);
    w.value = 32'sh00ABCDEF;    w.radix = 5'd16; words_to_send.push_back(w);
    w.value = -32'sd255;        w.radix = 5'd16; words_to_send.push_back(w);
    w.value = 32'sd12345;       w.radix = 5'd0;  words_to_send.push_back(w);
    w.value = -32'sd12345;      w.radix = 5'd1;  words_to_send.push_back(w);
    w.value = 32'sd48879;       w.radix = 5'd17; words_to_send.push_back(w);
    w.value = 32'sd80;          w.radix = 5'd3;  words_to_send.push_back(w);
    w.value = -32'sd342;        w.radix = 5'd7;  words_to_send.push_back(w);
    w.value = 32'sd15;          w.radix = 5'd15; words_to_send.push_back(w);
    w.upper_case = 1'b1;
    w.value = 32'sh00ABCDEF;    w.radix = 5'd16; words_to_send.push_back(w);
    w.value = 32'sh80000000;    w.radix = 5'd16; words_to_send.push_back(w);
    w.value = -32'sd48879;      w.radix = 5'd31; words_to_send.push_back(w);
    w.value = 32'sd2147483547;  w.radix = 5'd14; words_to_send.push_back(w);
    w.value = 32'sd0;           w.radix = 5'd16; words_to_send.push_back(w);
    while (words_to_send.size() > 0) @(posedge clk_i);

    for (phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (n = 0; n < WordsPerPhase; n++) begin
        // Small magnitudes keep some words short; full-range values, powers
        // of two and the range ends reach the long digit strings.
        case ($urandom_range(5))
          0, 5: w.value = $urandom;
          1: w.value = $urandom_range(300);
          2: w.value = -$urandom_range(300, 1);
          3: begin
            case ($urandom_range(4))
              0: w.value = 32'sh80000000;
              1: w.value = 32'sh7FFFFFFF;
              2: w.value = 32'sh80000001;
              3: w.value = -32'sd1;
              default: w.value = 32'sd0;
            endcase
          end
          default: begin
            mag = 32'd1 << $urandom_range(31);
            if ($urandom_range(1)) begin
              mag = mag - 32'd1;
            end
            w.value = $urandom_range(1) ? -mag : mag;
          end
        endcase
        // Mostly legal bases, with the whole 5-bit field now and then.
        w.radix = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                           : 5'($urandom_range(16, 2));
        w.upper_case = 1'($urandom_range(1));
        words_to_send.push_back(w);
      end
      while (words_to_send.size() > 0) @(posedge clk_i);
    end

    // Let everything drain, then watch a while longer for stray words.
    while (push_i || chars_owed.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (num_errors == 0) begin
      $display("signed_int_to_base_ascii_top test passed");
    end else begin
      $display("signed_int_to_base_ascii_top test failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs; well above the slowest legal run.
  initial begin
    #2000000;
    $display("signed_int_to_base_ascii_top test failed");
    $finish;
  end

endmodule
